// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define CGSU_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define CGSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define CGSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/cgsu_pkg.sv =====
// ----------------------------------------------------------------------------
// cgsu_pkg
// Types, codes and helpers shared by the gate state update block.
// ----------------------------------------------------------------------------
package cgsu_pkg;

  localparam int MAX_QUBITS_DEF  = 10;
  localparam int MAX_TARGETS_DEF = 3;
  localparam int AMP_BITS_DEF    = 16;

  localparam int INDEX_W    = 10;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int QC_W       = 4;
  localparam int TC_W       = 2;
  localparam int TQ_W       = 4;
  localparam int CM_W       = 10;
  localparam int TREG_N     = 3;
  localparam int ACC_W      = 64;

  typedef enum logic [1:0] {
    MODE_WR_AMP = 2'd0,
    MODE_WR_MAT = 2'd1,
    MODE_APPLY  = 2'd2,
    MODE_RD_AMP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_QUBIT_COUNT   = 3'd0,
    REG_TARGET_COUNT  = 3'd1,
    REG_TARGET_FIRST  = 3'd2,
    REG_TARGET_SECOND = 3'd3,
    REG_TARGET_THIRD  = 3'd4,
    REG_CONTROL_MASK  = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_GATH_RD,
    S_GATH_WR,
    S_MAC,
    S_DRAIN,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic exec_write;
    logic read_issue;
    logic base_clr;
    logic base_inc;
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic gather_rd;
    logic gather_wr;
    logic mac_issue;
    logic acc_clr;
    logic amp_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  bad_target;
    logic  base_end;
    logic  eligible;
    logic  i_last;
    logic  mac_last;
    logic  mac_busy;
    logic  out_free;
  } sts_t;

  // Signed addition that clamps at the limits of the accumulator.
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

// ===== sv/cgsu_if.sv =====
// ----------------------------------------------------------------------------
// cgsu_item_if / cgsu_result_if
// Valid-ready channels carrying the item and result transactions.
// ----------------------------------------------------------------------------
interface cgsu_item_if #(
  parameter int AMP_BITS = cgsu_pkg::AMP_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic [cgsu_pkg::INDEX_W-1:0]      index;
  logic signed [AMP_BITS-1:0]        value_re;
  logic signed [AMP_BITS-1:0]        value_im;

  modport source(output valid, mode, index, value_re, value_im, input ready);
  modport sink(input valid, mode, index, value_re, value_im, output ready);
endinterface

interface cgsu_result_if #(
  parameter int AMP_BITS = cgsu_pkg::AMP_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [AMP_BITS-1:0] amp_re;
  logic signed [AMP_BITS-1:0] amp_im;
  logic                       status;

  modport source(output valid, amp_re, amp_im, status, input ready);
  modport sink(input valid, amp_re, amp_im, status, output ready);
endinterface

// ===== sv/cgsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// cgsu_ctrl
// Sequencer for item execution and the gate apply walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cgsu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  cgsu_pkg::sts_t sts,
  output cgsu_pkg::cmd_t cmd
);

  cgsu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgsu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cgsu_pkg::S_IDLE: begin
        if (item_valid) state_next = cgsu_pkg::S_EXEC;
      end
      cgsu_pkg::S_EXEC: begin
        if (sts.mode == cgsu_pkg::MODE_APPLY && !sts.bad_target) begin
          state_next = cgsu_pkg::S_SCAN;
        end else begin
          state_next = cgsu_pkg::S_DONE;
        end
      end
      cgsu_pkg::S_SCAN: begin
        if (sts.base_end) state_next = cgsu_pkg::S_DONE;
        else if (sts.eligible) state_next = cgsu_pkg::S_GATH_RD;
      end
      cgsu_pkg::S_GATH_RD: state_next = cgsu_pkg::S_GATH_WR;
      cgsu_pkg::S_GATH_WR: begin
        state_next = sts.i_last ? cgsu_pkg::S_MAC : cgsu_pkg::S_GATH_RD;
      end
      cgsu_pkg::S_MAC: begin
        if (sts.mac_last) state_next = cgsu_pkg::S_DRAIN;
      end
      cgsu_pkg::S_DRAIN: begin
        if (!sts.mac_busy) state_next = cgsu_pkg::S_WRITE;
      end
      cgsu_pkg::S_WRITE: begin
        state_next = sts.i_last ? cgsu_pkg::S_SCAN : cgsu_pkg::S_MAC;
      end
      cgsu_pkg::S_DONE: begin
        if (sts.out_free) state_next = cgsu_pkg::S_IDLE;
      end
      default: state_next = cgsu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      cgsu_pkg::S_IDLE: begin
        item_ready    = 1'b1;
        cmd.load_item = item_valid;
      end
      cgsu_pkg::S_EXEC: begin
        case (sts.mode)
          cgsu_pkg::MODE_WR_AMP: cmd.exec_write = 1'b1;
          cgsu_pkg::MODE_WR_MAT: cmd.exec_write = 1'b1;
          cgsu_pkg::MODE_RD_AMP: cmd.read_issue = 1'b1;
          cgsu_pkg::MODE_APPLY:  cmd.base_clr   = 1'b1;
          default:               cmd            = '0;
        endcase
      end
      cgsu_pkg::S_SCAN: begin
        if (!sts.base_end) begin
          if (sts.eligible) cmd.i_clr = 1'b1;
          else cmd.base_inc = 1'b1;
        end
      end
      cgsu_pkg::S_GATH_RD: cmd.gather_rd = 1'b1;
      cgsu_pkg::S_GATH_WR: begin
        cmd.gather_wr = 1'b1;
        if (sts.i_last) begin
          cmd.i_clr   = 1'b1;
          cmd.j_clr   = 1'b1;
          cmd.acc_clr = 1'b1;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      cgsu_pkg::S_MAC: cmd.mac_issue = 1'b1;
      cgsu_pkg::S_WRITE: begin
        cmd.amp_wr  = 1'b1;
        cmd.j_clr   = 1'b1;
        cmd.acc_clr = 1'b1;
        if (sts.i_last) cmd.base_inc = 1'b1;
        else cmd.i_inc = 1'b1;
      end
      cgsu_pkg::S_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  `CGSU_ASSERT_IMP(a_write_after_drain, cmd.amp_wr, !sts.mac_busy)
  `CGSU_ASSERT_IMP(a_load_into_free_out, cmd.out_load, sts.out_free)
  `CGSU_ASSERT_NEXT(a_walk_ends_in_done, state == cgsu_pkg::S_SCAN && sts.base_end,
                    state == cgsu_pkg::S_DONE)

endmodule

// ===== sv/cgsu_datapath.sv =====
// ----------------------------------------------------------------------------
// cgsu_datapath
// Configuration, amplitude and matrix memories, complex MAC and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cgsu_datapath #(
  parameter int MAX_QUBITS  = cgsu_pkg::MAX_QUBITS_DEF,
  parameter int MAX_TARGETS = cgsu_pkg::MAX_TARGETS_DEF,
  parameter int AMP_BITS    = cgsu_pkg::AMP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cgsu_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cgsu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  cgsu_pkg::cmd_t                  cmd,
  output cgsu_pkg::sts_t                  sts,
  input  logic [1:0]                      in_mode,
  input  logic [cgsu_pkg::INDEX_W-1:0]    in_index,
  input  logic signed [AMP_BITS-1:0]      in_re,
  input  logic signed [AMP_BITS-1:0]      in_im,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic signed [AMP_BITS-1:0]      out_re,
  output logic signed [AMP_BITS-1:0]      out_im,
  output logic                            out_status
);

  localparam int QW         = MAX_QUBITS;
  localparam int MT         = MAX_TARGETS;
  localparam int AW         = AMP_BITS;
  localparam int FRAC       = AW - 2;
  localparam int STATE_SIZE = 1 << QW;
  localparam int MAT_DIM    = 1 << MT;
  localparam int MAT_AW     = 2 * MT;
  localparam int MAT_SIZE   = 1 << MAT_AW;
  localparam int NW         = $clog2(QW + 1);
  localparam int KW         = $clog2(MT + 1);
  localparam int ACC_W      = cgsu_pkg::ACC_W;

  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] AMAX = (ACC_W'(1) << (AW - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] AMIN = -AMAX - ACC_W'(1);

  // Round to nearest with ties upward, drop the fraction and clamp to the amplitude range.
  function automatic logic signed [AW-1:0] fin(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = cgsu_pkg::sat_add(acc, RND) >>> FRAC;
    if (t > AMAX) fin = AMAX[AW-1:0];
    else if (t < AMIN) fin = AMIN[AW-1:0];
    else fin = t[AW-1:0];
  endfunction

  // Configuration registers.
  logic [cgsu_pkg::QC_W-1:0] qubit_count;
  logic [cgsu_pkg::TC_W-1:0] target_count;
  logic [cgsu_pkg::TQ_W-1:0] tq [cgsu_pkg::TREG_N];
  logic [cgsu_pkg::CM_W-1:0] control_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      qubit_count  <= cgsu_pkg::QC_W'(10);
      target_count <= cgsu_pkg::TC_W'(1);
      tq[0]        <= cgsu_pkg::TQ_W'(0);
      tq[1]        <= cgsu_pkg::TQ_W'(1);
      tq[2]        <= cgsu_pkg::TQ_W'(2);
      control_mask <= '0;
    end else if (cfg_write) begin
      case (cgsu_pkg::cfg_reg_t'(cfg_addr))
        cgsu_pkg::REG_QUBIT_COUNT:   qubit_count  <= cfg_data[cgsu_pkg::QC_W-1:0];
        cgsu_pkg::REG_TARGET_COUNT:  target_count <= cfg_data[cgsu_pkg::TC_W-1:0];
        cgsu_pkg::REG_TARGET_FIRST:  tq[0]        <= cfg_data[cgsu_pkg::TQ_W-1:0];
        cgsu_pkg::REG_TARGET_SECOND: tq[1]        <= cfg_data[cgsu_pkg::TQ_W-1:0];
        cgsu_pkg::REG_TARGET_THIRD:  tq[2]        <= cfg_data[cgsu_pkg::TQ_W-1:0];
        cgsu_pkg::REG_CONTROL_MASK:  control_mask <= cfg_data[cgsu_pkg::CM_W-1:0];
        default: ;
      endcase
    end
  end

  // Item held for the duration of its execution.
  cgsu_pkg::mode_t              it_mode;
  logic [cgsu_pkg::INDEX_W-1:0] it_index;
  logic signed [AW-1:0]         it_re, it_im;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_mode  <= cgsu_pkg::mode_t'(in_mode);
      it_index <= in_index;
      it_re    <= in_re;
      it_im    <= in_im;
    end
  end

  // Geometry of the current gate.
  logic [NW-1:0] n;
  logic [KW-1:0] k;
  logic [QW:0]   size;
  logic [MT:0]   dim;
  logic [QW-1:0] tmask, cmask;
  logic          bad_target;

  assign n    = (int'(qubit_count) > QW) ? NW'(QW) : NW'(qubit_count);
  assign k    = (int'(target_count) > MT) ? KW'(MT) : KW'(target_count);
  assign size = (QW + 1)'(1) << n;
  assign dim  = (MT + 1)'(1) << k;

  always_comb begin
    bad_target = 1'b0;
    tmask      = '0;
    for (int b = 0; b < cgsu_pkg::TREG_N; b++) begin
      if (b < int'(k)) begin
        if (int'(tq[b]) >= int'(n)) bad_target = 1'b1;
        tmask = tmask | (QW'(1) << tq[b]);
      end
    end
  end

  assign cmask = QW'(control_mask) & QW'(size - (QW + 1)'(1)) & ~tmask;

  // Walk counters.
  logic [QW:0] base;
  logic [MT:0] cnt_i, cnt_j;

  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= '0;
      cnt_i <= '0;
      cnt_j <= '0;
    end else begin
      if (cmd.base_clr) base <= '0;
      else if (cmd.base_inc) base <= base + (QW + 1)'(1);
      if (cmd.i_clr) cnt_i <= '0;
      else if (cmd.i_inc) cnt_i <= cnt_i + (MT + 1)'(1);
      if (cmd.j_clr) cnt_j <= '0;
      else if (cmd.mac_issue) cnt_j <= cnt_j + (MT + 1)'(1);
    end
  end

  // Amplitude index of group member cnt_i: its bits placed on the target qubits.
  logic [QW-1:0] amp_idx;

  always_comb begin
    amp_idx = base[QW-1:0];
    for (int b = 0; b < cgsu_pkg::TREG_N; b++) begin
      if (b < int'(k) && ((int'(cnt_i) >> b) & 1) != 0) begin
        amp_idx = amp_idx | (QW'(1) << tq[b]);
      end
    end
  end

  logic amp_oor, mat_oor;
  assign amp_oor = (32'(it_index) >> n) != 0;
  assign mat_oor = (32'(it_index) >> MAT_AW) != 0;

  // Accumulators and the finished amplitude.
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic signed [AW-1:0]    fin_re, fin_im;
  assign fin_re = fin(acc_re);
  assign fin_im = fin(acc_im);

  // Amplitude memory.
  logic [2*AW-1:0] amp_mem [STATE_SIZE];
  logic [2*AW-1:0] amp_q;
  logic            amp_we, amp_rd;
  logic [QW-1:0]   amp_waddr, amp_raddr;
  logic [2*AW-1:0] amp_wdata;

  assign amp_we    = cmd.amp_wr ||
                     (cmd.exec_write && it_mode == cgsu_pkg::MODE_WR_AMP && !amp_oor);
  assign amp_waddr = cmd.amp_wr ? amp_idx : QW'(it_index);
  assign amp_wdata = cmd.amp_wr ? {fin_re, fin_im} : {it_re, it_im};
  assign amp_rd    = cmd.read_issue || cmd.gather_rd;
  assign amp_raddr = cmd.read_issue ? QW'(it_index) : amp_idx;

  always_ff @(posedge clk) begin
    if (amp_we) amp_mem[amp_waddr] <= amp_wdata;
    if (amp_rd) amp_q <= amp_mem[amp_raddr];
  end

  // Gate matrix memory, addressed as row then column.
  logic [2*AW-1:0] mat_mem [MAT_SIZE];
  logic [2*AW-1:0] m_q;

  always_ff @(posedge clk) begin
    if (cmd.exec_write && it_mode == cgsu_pkg::MODE_WR_MAT && !mat_oor) begin
      mat_mem[it_index[MAT_AW-1:0]] <= {it_re, it_im};
    end
    if (cmd.mac_issue) m_q <= mat_mem[{cnt_i[MT-1:0], cnt_j[MT-1:0]}];
  end

  // Gather buffer holding the group's input amplitudes.
  logic [2*AW-1:0] gbuf [MAT_DIM];
  logic [2*AW-1:0] g_q;

  always_ff @(posedge clk) begin
    if (cmd.gather_wr) gbuf[cnt_i[MT-1:0]] <= amp_q;
    if (cmd.mac_issue) g_q <= gbuf[cnt_j[MT-1:0]];
  end

  // Complex multiply-accumulate: operand fetch, products, accumulate.
  logic p1, p2;
  logic signed [AW-1:0]   m_re, m_im, g_re, g_im;
  logic signed [2*AW-1:0] p_rr, p_ii, p_ri, p_ir;

  assign m_re = m_q[2*AW-1:AW];
  assign m_im = m_q[AW-1:0];
  assign g_re = g_q[2*AW-1:AW];
  assign g_im = g_q[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= cmd.mac_issue;
      p2 <= p1;
    end
  end

  always_ff @(posedge clk) begin
    if (p1) begin
      p_rr <= m_re * g_re;
      p_ii <= m_im * g_im;
      p_ri <= m_re * g_im;
      p_ir <= m_im * g_re;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (p2) begin
      acc_re <= cgsu_pkg::sat_add(cgsu_pkg::sat_add(acc_re, ACC_W'(p_rr)), -ACC_W'(p_ii));
      acc_im <= cgsu_pkg::sat_add(cgsu_pkg::sat_add(acc_im, ACC_W'(p_ri)), ACC_W'(p_ir));
    end
  end

  // Result register.
  logic out_free, res_status, res_data;
  assign out_free = !out_valid || out_ready;
  assign res_data = (it_mode == cgsu_pkg::MODE_RD_AMP) && !amp_oor;

  always_comb begin
    case (it_mode)
      cgsu_pkg::MODE_WR_AMP: res_status = amp_oor;
      cgsu_pkg::MODE_RD_AMP: res_status = amp_oor;
      cgsu_pkg::MODE_WR_MAT: res_status = mat_oor;
      cgsu_pkg::MODE_APPLY:  res_status = bad_target;
      default:               res_status = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_re     <= res_data ? amp_q[2*AW-1:AW] : '0;
      out_im     <= res_data ? amp_q[AW-1:0] : '0;
    end
  end

  assign sts.mode       = it_mode;
  assign sts.bad_target = bad_target;
  assign sts.base_end   = (base == size);
  assign sts.eligible   = ((base[QW-1:0] & tmask) == '0) &&
                          ((base[QW-1:0] & cmask) == cmask);
  assign sts.i_last     = (cnt_i == dim - (MT + 1)'(1));
  assign sts.mac_last   = (cnt_j == dim - (MT + 1)'(1));
  assign sts.mac_busy   = p1 || p2;
  assign sts.out_free   = out_free;

  `CGSU_ASSERT_ALWAYS(a_col_within_dim, cnt_j <= dim)
  `CGSU_ASSERT_IMP(a_no_clear_in_flight, cmd.acc_clr, !(p1 || p2))

endmodule

// ===== sv/controlled_gate_state_update.sv =====
// ----------------------------------------------------------------------------
// controlled_gate_state_update
// Applies a controlled gate of up to three target qubits to a stored state.
// ----------------------------------------------------------------------------
// The block holds 2^MAX_QUBITS complex amplitudes and a gate matrix of
// 2^MAX_TARGETS square entries, all in Q2.14 two's complement. Each item
// transaction writes an amplitude, writes a matrix entry, reads an amplitude
// or applies the gate, and yields exactly one result transaction. A write or
// read is executed once accepted, and its result is loaded into the output
// register as soon as that register is free. An apply walks every base index
// of the state once (2^n indices for n qubits), and for each group whose
// control bits are set and target bits are clear it gathers the group's dim
// amplitudes through the single read port of the amplitude memory, then forms
// the new amplitudes with one complex multiply-accumulate per cycle (four
// real multipliers), drains the pipeline and writes each one back, where dim =
// 2^k for k targets. The block takes one item at a time; a finished result
// waits in an output register, so the next item is accepted while it is
// still to be taken. Configuration registers are written through the plain
// write port; the user must write them only while the block is idle, as the
// block itself does not enforce this. Memories are not cleared at reset, so
// amplitudes and matrix entries must be written before they are read or used.
// ----------------------------------------------------------------------------
module controlled_gate_state_update #(
  parameter int MAX_QUBITS  = cgsu_pkg::MAX_QUBITS_DEF,
  parameter int MAX_TARGETS = cgsu_pkg::MAX_TARGETS_DEF,
  parameter int AMP_BITS    = cgsu_pkg::AMP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cgsu_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cgsu_pkg::CFG_DATA_W-1:0] cfg_data,
  cgsu_item_if.sink                       item,
  cgsu_result_if.source                   result
);

  cgsu_pkg::cmd_t cmd;
  cgsu_pkg::sts_t sts;

  // The sequencer decides what happens in each cycle; the datapath holds all
  // storage and arithmetic and reports back the conditions it needs.
  cgsu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cgsu_datapath #(
    .MAX_QUBITS  (MAX_QUBITS),
    .MAX_TARGETS (MAX_TARGETS),
    .AMP_BITS    (AMP_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (item.mode),
    .in_index   (item.index),
    .in_re      (item.value_re),
    .in_im      (item.value_im),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .out_re     (result.amp_re),
    .out_im     (result.amp_im),
    .out_status (result.status)
  );

endmodule
